>>> hdl/jddm_pkg.sv
package jddm_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned DutyBits   = 10;
  localparam int unsigned SpeedBits  = 11;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits    = 12;
  localparam int unsigned QuotBits   = 11;
  localparam int unsigned DivCount   = 22;

  localparam logic [SampleBits-1:0] FullScale = {SampleBits{1'b1}};

  localparam logic [CfgIdxBits-1:0] RegCentreX   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegCentreY   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegDeadZone  = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegPwmMax    = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegTurnMin   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegMinMove   = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegThreshold = 3'd6;

  localparam logic [2:0] DirCentre   = 3'd0;
  localparam logic [2:0] DirForward  = 3'd1;
  localparam logic [2:0] DirBackward = 3'd2;
  localparam logic [2:0] DirLeft     = 3'd3;
  localparam logic [2:0] DirRight    = 3'd4;

  // Classified request passed from the front to the back part.
  typedef struct packed {
    logic                   mode;
    logic signed [12:0]     dx;
    logic signed [12:0]     dy;
  } item_t;

endpackage

>>> hdl/jddm_front.sv
module jddm_front import jddm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [SampleBits-1:0] sample_x_i,
  input  logic [SampleBits-1:0] sample_y_i,
  input  logic                  mode_active_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [11:0]           centre_x_i,
  input  logic [11:0]           centre_y_i,
  input  logic [10:0]           deadband_i,
  output item_t                 item_o,
  output logic                  item_valid_o,
  input  logic                  item_ready_i
);

  item_t item_q, item_d;
  logic  full_q;
  logic signed [12:0] dx, dy, ax, ay;

  always_comb begin
    dx = $signed({1'b0, sample_x_i}) - $signed({1'b0, centre_x_i});
    dy = $signed({1'b0, sample_y_i}) - $signed({1'b0, centre_y_i});
    ax = dx[12] ? -dx : dx;
    ay = dy[12] ? -dy : dy;
    item_d.mode = mode_active_i;
    item_d.dx   = (ax < $signed({2'b0, deadband_i})) ? '0 : dx;
    item_d.dy   = (ay < $signed({2'b0, deadband_i})) ? '0 : dy;
  end

  assign ready_o      = !full_q || item_ready_i;
  assign item_o       = item_q;
  assign item_valid_o = full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (ready_o) begin
      full_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

>>> hdl/jddm_div.sv
module jddm_div import jddm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [21:0]   num_i,
  input  logic [11:0]   den_i,
  output logic          done_o,
  output logic [21:0]   quot_o
);

  // Restoring divider, one quotient bit per cycle.
  logic [21:0] quot_q;
  logic [12:0] rem_q;
  logic [4:0]  cnt_q;
  logic [11:0] den_q;
  logic        busy_q;
  logic [12:0] trial;
  logic [13:0] diff;

  always_comb begin
    trial = {rem_q[11:0], quot_q[21]};
    diff  = {1'b0, trial} - {2'b0, den_q};
  end

  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(DivCount - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (!diff[13]) begin
        rem_q  <= diff[12:0];
        quot_q <= {quot_q[20:0], 1'b1};
      end else begin
        rem_q  <= trial;
        quot_q <= {quot_q[20:0], 1'b0};
      end
    end
  end

endmodule

>>> hdl/jddm_back.sv
module jddm_back import jddm_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  item_t                       item_i,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  logic [11:0]                 centre_x_i,
  input  logic [11:0]                 centre_y_i,
  input  logic [9:0]                  pwm_max_i,
  input  logic [9:0]                  turn_min_i,
  input  logic [9:0]                  min_move_i,
  input  logic [10:0]                 threshold_i,
  output logic signed [SpeedBits-1:0] left_wheel_o,
  output logic signed [SpeedBits-1:0] right_wheel_o,
  output logic [2:0]                  direction_o,
  output logic                        updated_o,
  output logic [DutyBits-1:0]         left_fwd_duty_o,
  output logic [DutyBits-1:0]         left_rev_duty_o,
  output logic [DutyBits-1:0]         right_fwd_duty_o,
  output logic [DutyBits-1:0]         right_rev_duty_o,
  output logic                        valid_o,
  input  logic                        ready_i
);

  typedef enum logic [2:0] {
    StIdle, StDivX, StWaitX, StDivY, StWaitY, StMix, StOut
  } state_e;

  state_e state_q;
  item_t  it_q;
  logic signed [11:0] base_q, turn_q;
  logic [2:0]  last_dir_q;
  logic signed [11:0] last_l_q, last_r_q;
  logic signed [10:0] app_l_q, app_r_q;

  logic        div_start, div_done;
  logic [21:0] div_num, div_quot;
  logic [11:0] div_den;
  logic signed [12:0] dcur;
  logic [11:0] ccur, prange, nrange, rng, mag;
  logic        zero_div;
  logic signed [11:0] scaled;

  // Divider operand for the axis in hand.
  always_comb begin
    dcur   = (state_q == StDivX) ? it_q.dx : it_q.dy;
    ccur   = (state_q == StDivX) ? centre_x_i : centre_y_i;
    prange = FullScale - ccur;
    nrange = ccur;
    rng    = dcur[12] ? nrange : prange;
    mag    = dcur[12] ? 12'(-dcur) : dcur[11:0];
    div_num = {10'b0, mag} * {12'b0, pwm_max_i};
    div_den = rng;
    zero_div = (dcur == '0) || (rng == '0);
    div_start = (state_q == StDivX || state_q == StDivY) && !zero_div;
  end

  jddm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  // Quotient limited to pwm_max then given the sign of the deflection.
  logic [9:0] qlim;
  logic       ysgn;
  always_comb begin
    qlim = (div_quot > {12'b0, pwm_max_i}) ? pwm_max_i : div_quot[9:0];
    ysgn = (state_q == StWaitX) ? it_q.dx[12] : it_q.dy[12];
    scaled = ysgn ? -$signed({2'b0, qlim}) : $signed({2'b0, qlim});
  end

  // Mixing and refresh decision.
  logic signed [12:0] sum, dif, pmx, l0, r0, l1, r1, dl, dr;
  logic signed [12:0] adx, ady;
  logic [2:0]  dir;
  logic        upd;
  always_comb begin
    pmx = $signed({3'b0, pwm_max_i});
    sum = base_q + turn_q;
    dif = base_q - turn_q;
    l0 = (sum > pmx) ? pmx : (sum < -pmx) ? -pmx : sum;
    r0 = (dif > pmx) ? pmx : (dif < -pmx) ? -pmx : dif;
    l1 = l0;
    r1 = r0;
    if (turn_q != '0 && !base_q[11]) begin
      if (l0 < 0) l1 = $signed({3'b0, turn_min_i});
      if (r0 < 0) r1 = $signed({3'b0, turn_min_i});
    end else if (turn_q != '0) begin
      if (l0 > 0) l1 = -$signed({3'b0, turn_min_i});
      if (r0 > 0) r1 = -$signed({3'b0, turn_min_i});
    end
    adx = it_q.dx[12] ? -it_q.dx : it_q.dx;
    ady = it_q.dy[12] ? -it_q.dy : it_q.dy;
    if (it_q.dx == '0 && it_q.dy == '0) dir = DirCentre;
    else if (ady >= adx) dir = it_q.dy[12] ? DirLeft : DirRight;
    else dir = it_q.dx[12] ? DirBackward : DirForward;
    dl = l1 - last_l_q;
    dr = r1 - last_r_q;
    if (dl[12]) dl = -dl;
    if (dr[12]) dr = -dr;
    upd = (dir != last_dir_q) || (dl > $signed({2'b0, threshold_i}))
          || (dr > $signed({2'b0, threshold_i}));
  end

  function automatic logic [DutyBits-1:0] fwd_duty(logic signed [10:0] s,
                                                    logic [9:0] mm);
    logic [9:0] m;
    m = s[10] ? 10'(-s) : s[9:0];
    if (m != '0 && m < mm) m = mm;
    return (s > 0) ? m : '0;
  endfunction

  function automatic logic [DutyBits-1:0] rev_duty(logic signed [10:0] s,
                                                    logic [9:0] mm);
    logic [9:0] m;
    m = s[10] ? 10'(-s) : s[9:0];
    if (m != '0 && m < mm) m = mm;
    return (s < 0) ? m : '0;
  endfunction

  assign item_ready_o = (state_q == StIdle);
  assign valid_o      = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      base_q     <= '0;
      turn_q     <= '0;
      last_dir_q <= DirCentre;
      last_l_q   <= '0;
      last_r_q   <= '0;
      app_l_q    <= '0;
      app_r_q    <= '0;
      updated_o  <= 1'b0;
      direction_o <= DirCentre;
    end else begin
      unique case (state_q)
        StIdle: if (item_valid_i) state_q <= StDivX;
        StDivX: begin
          if (zero_div) begin
            base_q  <= '0;
            state_q <= StDivY;
          end else state_q <= StWaitX;
        end
        StWaitX: if (div_done) begin
          base_q  <= scaled;
          state_q <= StDivY;
        end
        StDivY: begin
          if (zero_div) begin
            turn_q  <= '0;
            state_q <= StMix;
          end else state_q <= StWaitY;
        end
        StWaitY: if (div_done) begin
          turn_q  <= scaled;
          state_q <= StMix;
        end
        StMix: begin
          updated_o   <= it_q.mode && upd;
          direction_o <= it_q.mode ? dir : DirCentre;
          if (!it_q.mode) begin
            app_l_q <= '0;
            app_r_q <= '0;
          end else if (upd) begin
            last_dir_q <= dir;
            last_l_q   <= l1[11:0];
            last_r_q   <= r1[11:0];
            app_l_q <= (l1 > pmx) ? pmx[10:0] : (l1 < -pmx) ? 11'(-pmx) : l1[10:0];
            app_r_q <= (r1 > pmx) ? pmx[10:0] : (r1 < -pmx) ? 11'(-pmx) : r1[10:0];
          end
          state_q <= StOut;
        end
        StOut: if (ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && item_valid_i) it_q <= item_i;
  end

  assign left_wheel_o     = app_l_q;
  assign right_wheel_o    = app_r_q;
  assign left_fwd_duty_o  = fwd_duty(app_l_q, min_move_i);
  assign left_rev_duty_o  = rev_duty(app_l_q, min_move_i);
  assign right_fwd_duty_o = fwd_duty(app_r_q, min_move_i);
  assign right_rev_duty_o = rev_duty(app_r_q, min_move_i);

endmodule

>>> hdl/joystick_differential_drive_mixer.sv
// Axes with a non-zero deflection and range go through the shared divider in
// turn. The back part takes a new request only once the last result has been
// accepted; the front register can hold one more request meanwhile.
// Reset (rst_ni, asynchronous, active low) restores the register defaults and
// clears the applied speeds, the comparison state and all handshakes.
module joystick_differential_drive_mixer import jddm_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [CfgBits-1:0]          cfg_data_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [SampleBits-1:0]       sample_x_i,
  input  logic [SampleBits-1:0]       sample_y_i,
  input  logic                        mode_active_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [SpeedBits-1:0] left_wheel_o,
  output logic signed [SpeedBits-1:0] right_wheel_o,
  output logic [2:0]                  direction_o,
  output logic                        updated_o,
  output logic [DutyBits-1:0]         left_fwd_duty_o,
  output logic [DutyBits-1:0]         left_rev_duty_o,
  output logic [DutyBits-1:0]         right_fwd_duty_o,
  output logic [DutyBits-1:0]         right_rev_duty_o
);

  logic [11:0] centre_x_q, centre_y_q;
  logic [10:0] deadband_q, threshold_q;
  logic [9:0]  pwm_max_q, turn_min_q, min_move_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q  <= 12'd2048;
      centre_y_q  <= 12'd2048;
      deadband_q  <= 11'd200;
      pwm_max_q   <= 10'd1023;
      turn_min_q  <= 10'd200;
      min_move_q  <= 10'd150;
      threshold_q <= 11'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCentreX:   centre_x_q  <= cfg_data_i;
        RegCentreY:   centre_y_q  <= cfg_data_i;
        RegDeadZone:  deadband_q  <= cfg_data_i[10:0];
        RegPwmMax:    pwm_max_q   <= cfg_data_i[9:0];
        RegTurnMin:   turn_min_q  <= cfg_data_i[9:0];
        RegMinMove:   min_move_q  <= cfg_data_i[9:0];
        RegThreshold: threshold_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  item_t item;
  logic  item_valid, item_ready;

  jddm_front u_front (
    .clk_i, .rst_ni, .sample_x_i, .sample_y_i, .mode_active_i, .valid_i, .ready_o,
    .centre_x_i(centre_x_q), .centre_y_i(centre_y_q), .deadband_i(deadband_q),
    .item_o(item), .item_valid_o(item_valid), .item_ready_i(item_ready)
  );

  jddm_back u_back (
    .clk_i, .rst_ni, .item_i(item), .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .centre_x_i(centre_x_q), .centre_y_i(centre_y_q), .pwm_max_i(pwm_max_q),
    .turn_min_i(turn_min_q), .min_move_i(min_move_q), .threshold_i(threshold_q),
    .left_wheel_o, .right_wheel_o, .direction_o, .updated_o,
    .left_fwd_duty_o, .left_rev_duty_o, .right_fwd_duty_o, .right_rev_duty_o,
    .valid_o, .ready_i
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import jddm_pkg::*;

  typedef struct packed {
    logic signed [SpeedBits-1:0] left;
    logic signed [SpeedBits-1:0] right;
    logic [2:0]                  dir;
    logic                        upd;
    logic [DutyBits-1:0]         lf;
    logic [DutyBits-1:0]         lr;
    logic [DutyBits-1:0]         rf;
    logic [DutyBits-1:0]         rr;
  } drive_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]       cfg_idx_i = '0;
  logic [CfgBits-1:0]          cfg_data_i = '0;
  logic                        valid_i = 1'b0;
  logic                        ready_o;
  logic [SampleBits-1:0]       sample_x_i = '0;
  logic [SampleBits-1:0]       sample_y_i = '0;
  logic                        mode_active_i = 1'b0;
  logic                        valid_o;
  logic                        ready_i = 1'b0;
  logic signed [SpeedBits-1:0] left_wheel_o;
  logic signed [SpeedBits-1:0] right_wheel_o;
  logic [2:0]                  direction_o;
  logic                        updated_o;
  logic [DutyBits-1:0]         left_fwd_duty_o;
  logic [DutyBits-1:0]         left_rev_duty_o;
  logic [DutyBits-1:0]         right_fwd_duty_o;
  logic [DutyBits-1:0]         right_rev_duty_o;

  joystick_differential_drive_mixer u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the block's registers and drive state.
  int centre_x, centre_y, deadband, pwm_max, turn_min, min_move, threshold;
  int last_dir, last_left, last_right, applied_left, applied_right;

  drive_t expected_drives[$];
  int     errors = 0;
  int     requests_sent;
  int     updates_seen = 0;
  bit     sender_idle_ok;
  bit     receiver_idle_ok;
  int     hold_requests = 0;
  int     holds_taken = 0;
  int     hold_cycles = 0;
  int     stall_left = 0;

  function automatic int abs_of(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int clamp(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int scaled_axis(int d, int pos_range, int neg_range);
    int v;
    if (d > 0 && pos_range > 0) begin
      v = (d * pwm_max) / pos_range;
      return v > pwm_max ? pwm_max : v;
    end
    if (d < 0 && neg_range > 0) begin
      v = (d * pwm_max) / neg_range;
      return v < -pwm_max ? -pwm_max : v;
    end
    return 0;
  endfunction

  function automatic void speed_duties(int speed, output logic [DutyBits-1:0] fwd,
                                       output logic [DutyBits-1:0] rev);
    int duty;
    duty = abs_of(speed);
    if (duty > 0 && duty < min_move) duty = min_move;
    if (duty > 1023) duty = 1023;
    fwd = speed > 0 ? duty[DutyBits-1:0] : '0;
    rev = speed < 0 ? duty[DutyBits-1:0] : '0;
  endfunction

  function automatic drive_t mix_sample(int sx, int sy, bit mode);
    drive_t r;
    int dx, dy, base, turn, l, rt, dir;
    dir = DirCentre;
    r.upd = 1'b0;
    if (mode) begin
      dx = sx - centre_x;
      dy = sy - centre_y;
      if (abs_of(dx) < deadband) dx = 0;
      if (abs_of(dy) < deadband) dy = 0;
      base = scaled_axis(dx, 4095 - centre_x, centre_x);
      turn = scaled_axis(dy, 4095 - centre_y, centre_y);
      l = clamp(base + turn, pwm_max);
      rt = clamp(base - turn, pwm_max);
      // A turn may slow a wheel but never spin it against the base direction.
      if (turn != 0 && base >= 0) begin
        if (l < 0) l = turn_min;
        if (rt < 0) rt = turn_min;
      end else if (turn != 0) begin
        if (l > 0) l = -turn_min;
        if (rt > 0) rt = -turn_min;
      end
      if (dx == 0 && dy == 0) dir = DirCentre;
      else if (abs_of(dy) >= abs_of(dx)) dir = dy < 0 ? DirLeft : DirRight;
      else dir = dx > 0 ? DirForward : DirBackward;
      if (dir != last_dir || abs_of(l - last_left) > threshold ||
          abs_of(rt - last_right) > threshold) begin
        applied_left = clamp(l, pwm_max);
        applied_right = clamp(rt, pwm_max);
        last_dir = dir;
        last_left = l;
        last_right = rt;
        r.upd = 1'b1;
      end
    end else begin
      applied_left = 0;
      applied_right = 0;
    end
    r.left = applied_left[SpeedBits-1:0];
    r.right = applied_right[SpeedBits-1:0];
    r.dir = dir[2:0];
    speed_duties(applied_left, r.lf, r.lr);
    speed_duties(applied_right, r.rf, r.rr);
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgBits-1:0];
    @(posedge clk_i);
    case (idx)
      RegCentreX:   centre_x = value;
      RegCentreY:   centre_y = value;
      RegDeadZone:  deadband = value;
      RegPwmMax:    pwm_max = value;
      RegTurnMin:   turn_min = value;
      RegMinMove:   min_move = value;
      RegThreshold: threshold = value;
      default: ;
    endcase
  endtask

  // The sender stops offering requests, then waits for every result.
  task automatic drain();
    valid_i <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_all(int cx, int cy, int dz, int pm, int tm, int mm, int th);
    drain();
    write_reg(RegCentreX, cx);
    write_reg(RegCentreY, cy);
    write_reg(RegDeadZone, dz);
    write_reg(RegPwmMax, pm);
    write_reg(RegTurnMin, tm);
    write_reg(RegMinMove, mm);
    write_reg(RegThreshold, th);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_sample(int sx, int sy, bit mode);
    if (sender_idle_ok && $urandom_range(0, 3) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    sample_x_i    <= sx[SampleBits-1:0];
    sample_y_i    <= sy[SampleBits-1:0];
    mode_active_i <= mode;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    expected_drives.push_back(mix_sample(sx, sy, mode));
    requests_sent++;
  endtask

  // Receiver: random stall bursts, or a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      ready_i <= 1'b0;
    end else if (holds_taken != hold_requests) begin
      holds_taken <= hold_requests;
      hold_cycles <= 399;
      ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      ready_i <= 1'b0;
    end else if (receiver_idle_ok && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      ready_i <= 1'b0;
    end else begin
      ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    drive_t want;
    if (rst_ni && valid_o && ready_i) begin
      if (expected_drives.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = expected_drives.pop_front();
        if (updated_o) updates_seen++;
        if (left_wheel_o !== want.left) begin
          $error("left_wheel exp %0d got %0d", want.left, left_wheel_o); errors++;
        end
        if (right_wheel_o !== want.right) begin
          $error("right_wheel exp %0d got %0d", want.right, right_wheel_o); errors++;
        end
        if (direction_o !== want.dir) begin
          $error("direction exp %0d got %0d", want.dir, direction_o); errors++;
        end
        if (updated_o !== want.upd) begin
          $error("updated exp %0d got %0d", want.upd, updated_o); errors++;
        end
        if (left_fwd_duty_o !== want.lf) begin
          $error("left_fwd_duty exp %0d got %0d", want.lf, left_fwd_duty_o); errors++;
        end
        if (left_rev_duty_o !== want.lr) begin
          $error("left_rev_duty exp %0d got %0d", want.lr, left_rev_duty_o); errors++;
        end
        if (right_fwd_duty_o !== want.rf) begin
          $error("right_fwd_duty exp %0d got %0d", want.rf, right_fwd_duty_o); errors++;
        end
        if (right_rev_duty_o !== want.rr) begin
          $error("right_rev_duty exp %0d got %0d", want.rr, right_rev_duty_o); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_sample(2048, 2048, 1'b1);
    send_sample(4095, 2048, 1'b1);
    send_sample(0, 2048, 1'b1);
    send_sample(2048, 0, 1'b1);
    send_sample(2048, 4095, 1'b1);
    send_sample(4095, 4095, 1'b1);
    send_sample(0, 0, 1'b1);
    send_sample(4095, 0, 1'b1);
    send_sample(0, 4095, 1'b1);
    send_sample(2300, 4095, 1'b1);
    send_sample(1800, 0, 1'b1);
    send_sample(2200, 2100, 1'b1);
    send_sample(2250, 2100, 1'b1);
    send_sample(4095, 4095, 1'b0);
    send_sample(2060, 2050, 1'b1);
    send_sample(2900, 2048, 1'b1);
    send_sample(2910, 2048, 1'b1);
    send_sample(1234, 3000, 1'b0);
  endtask

  // Zero side ranges, turn minimum above full scale, dead zone and threshold from none to maximum.
  task automatic test_edge_settings();
    set_all(4095, 0, 0, 1, 1023, 0, 0);
    send_sample(4095, 0, 1'b1);
    send_sample(0, 4095, 1'b1);
    send_sample(100, 4000, 1'b1);
    send_sample(4000, 100, 1'b1);
    set_all(0, 4095, 2047, 1023, 0, 1023, 2047);
    send_sample(4095, 0, 1'b1);
    send_sample(0, 4095, 1'b1);
    send_sample(2047, 2048, 1'b1);
    set_all(1000, 3000, 10, 300, 1023, 1023, 0);
    send_sample(2000, 4095, 1'b1);
    send_sample(0, 0, 1'b1);
    send_sample(900, 3500, 1'b1);
  endtask

  task automatic random_phase(int count);
    int sx, sy;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        sx = $urandom_range(0, 4095);
        sy = $urandom_range(0, 4095);
      end else begin
        // Joystick-like motion around the centre.
        sx = centre_x + $urandom_range(0, 1600) - 800;
        sy = centre_y + $urandom_range(0, 1600) - 800;
        sx = sx < 0 ? 0 : (sx > 4095 ? 4095 : sx);
        sy = sy < 0 ? 0 : (sy > 4095 ? 4095 : sy);
      end
      send_sample(sx, sy, $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      set_all($urandom_range(1500, 2600), $urandom_range(1500, 2600),
              $urandom_range(0, 400), $urandom_range(1, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 100));
      random_phase(220);
    end
    set_all($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 2047),
            $urandom_range(1, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
            $urandom_range(0, 2047));
    random_phase(150);
  endtask

  task automatic test_backpressure();
    set_all(2048, 2048, 200, 1023, 200, 150, 20);
    hold_requests++;
    for (int i = 0; i < 10; i++) send_sample($urandom_range(0, 4095),
                                            $urandom_range(0, 4095), 1'b1);
    // Pause until the block has emptied, then carry on.
    drain();
    for (int i = 0; i < 10; i++) send_sample($urandom_range(0, 4095),
                                            $urandom_range(0, 4095), 1'b1);
  endtask

  task automatic test_no_idle();
    sender_idle_ok = 1'b0;
    receiver_idle_ok = 1'b0;
    random_phase(200);
  endtask

  initial begin
    centre_x = 2048; centre_y = 2048; deadband = 200; pwm_max = 1023;
    turn_min = 200; min_move = 150; threshold = 20;
    last_dir = DirCentre; last_left = 0; last_right = 0;
    applied_left = 0; applied_right = 0;
    requests_sent = 0;
    sender_idle_ok = 1'b1; receiver_idle_ok = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_edge_settings();
    test_random();
    test_backpressure();
    test_no_idle();
    drain();
    $display("Covered %0d requests over several register settings, %0d drive refreshes,",
             requests_sent, updates_seen);
    $display("including stalls, a long receiver hold-off and a full drain.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
